// ----- rtl/core/cfsu_pkg.sv -----
// Shared constants, request and status codes and controller states for the call frame stack.
package cfsu_pkg;

  localparam int CFSU_STACK_DEPTH = 1024;
  localparam int CFSU_ENV_CELLS   = 4;
  localparam int CFSU_VIEW_DEPTH  = 16;

  localparam int REQ_W   = 4;
  localparam int OFF_W   = 10;
  localparam int WORD_W  = 32;
  localparam int PC_W    = 16;
  localparam int GC_W    = 10;
  localparam int PEND_W  = 10;
  localparam int DEPTH_W = 9;
  localparam int STAT_W  = 2;
  localparam int CELL_W  = WORD_W + 1;

  localparam logic [PEND_W-1:0]  PEND_MAX  = 10'd1023;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 9'd511;

  localparam logic [REQ_W-1:0] REQ_PUSH = 4'd0;
  localparam logic [REQ_W-1:0] REQ_CALL = 4'd1;
  localparam logic [REQ_W-1:0] REQ_RET  = 4'd2;
  localparam logic [REQ_W-1:0] REQ_LRD  = 4'd3;
  localparam logic [REQ_W-1:0] REQ_LWR  = 4'd4;
  localparam logic [REQ_W-1:0] REQ_ARD  = 4'd5;
  localparam logic [REQ_W-1:0] REQ_AWR  = 4'd6;
  localparam logic [REQ_W-1:0] REQ_GRD  = 4'd7;
  localparam logic [REQ_W-1:0] REQ_GWR  = 4'd8;
  localparam logic [REQ_W-1:0] REQ_UP   = 4'd9;
  localparam logic [REQ_W-1:0] REQ_DOWN = 4'd10;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVF   = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FRAME = 2'd3;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DEC, S_CALL, S_RT2, S_RT3, S_RT4,
    S_CLR, S_ARG, S_ACC, S_ACCW, S_DONE
  } cfsu_state_t;

endpackage

// ----- rtl/core/cfsu_cell_ram.sv -----
// Single-port stack cell memory with registered read data.
module cfsu_cell_ram
  import cfsu_pkg::*;
#(
  parameter int DEPTH = CFSU_STACK_DEPTH,
  parameter int AW    = $clog2(CFSU_STACK_DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     addr,
  input  logic [CELL_W-1:0] wdata,
  output logic [CELL_W-1:0] q_r
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    q_r <= mem[addr];
  end

endmodule

// ----- rtl/core/call_frame_stack_unit.sv -----
// Call frame stack: one request in, one result out, all cells held in a single-port memory.
//
// Every request passes through accept, decode and deliver states, sharing the one cell
// memory port; a call writes one environment cell per cycle, and a return clears each
// freed cell that it releases. After reset and after every global_count write the block
// clears the whole memory, one cell a cycle, and accepts no request until that pass is
// over. A new request is accepted while the previous result still waits in the output
// register.
module call_frame_stack_unit
  import cfsu_pkg::*;
#(
  parameter int STACK_DEPTH = CFSU_STACK_DEPTH,
  parameter int ENV_CELLS   = CFSU_ENV_CELLS,
  parameter int VIEW_DEPTH  = CFSU_VIEW_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  // req_type[3:0], offset[13:4], value[45:14], call_pc[61:46], zero[63:62]
  input  logic [63:0]     in_tdata,
  output logic            out_tvalid,
  input  logic            out_tready,
  // status[1:0], read_value[33:2], read_valid[34], return_pc[50:35], call_depth[59:51]
  output logic [63:0]     out_tdata,
  input  logic            cfg_wr_en,
  input  logic [GC_W-1:0] cfg_wr_data
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int IW  = ((AW > OFF_W) ? AW : OFF_W) + 3;
  localparam int VCW = $clog2(VIEW_DEPTH + 1);
  localparam int VAW = (VIEW_DEPTH > 1) ? $clog2(VIEW_DEPTH) : 1;
  localparam int CW  = $clog2(ENV_CELLS + 1);

  localparam logic signed [IW-1:0] TOPMAX  = IW'(STACK_DEPTH - 1);
  localparam logic signed [IW-1:0] SDI     = IW'(STACK_DEPTH);
  localparam logic signed [IW-1:0] ENVI    = IW'(ENV_CELLS);
  localparam logic [WORD_W-1:0]    SD_W    = WORD_W'(STACK_DEPTH);
  localparam logic [WORD_W-1:0]    TOPMAX_W = WORD_W'(STACK_DEPTH - 1);

  cfsu_state_t state_r, state_nxt;

  logic [GC_W-1:0]        gc_r, gc_nxt;
  logic signed [IW-1:0]   top_r, top_nxt, frame_r, frame_nxt;
  logic [PEND_W-1:0]      pend_r, pend_nxt;
  logic [DEPTH_W-1:0]     depth_r, depth_nxt;
  logic [VCW-1:0]         vcnt_r, vcnt_nxt;
  logic [REQ_W-1:0]       req_r, req_nxt;
  logic [OFF_W-1:0]       off_r, off_nxt;
  logic [WORD_W-1:0]      val_r, val_nxt;
  logic [PC_W-1:0]        pc_r, pc_nxt;
  logic [STAT_W-1:0]      status_r, status_nxt;
  logic [WORD_W-1:0]      rval_r, rval_nxt;
  logic                   rok_r, rok_nxt;
  logic [PC_W-1:0]        rpc_r, rpc_nxt;
  logic signed [IW-1:0]   idx_r, idx_nxt;
  logic signed [IW-1:0]   ptr_r, ptr_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic signed [IW-1:0]   tmp_top_r, tmp_top_nxt, tmp_frame_r, tmp_frame_nxt;
  logic                   oor_r, oor_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [63:0]            out_data_r, out_data_nxt;

  logic                   mem_we;
  logic [AW-1:0]          mem_addr;
  logic [CELL_W-1:0]      mem_wdata, mem_q;
  logic signed [IW-1:0]   mem_a;

  logic [2*IW-1:0]        vs_mem [VIEW_DEPTH];
  logic [2*IW-1:0]        vs_q_r;
  logic                   vs_we;
  logic [VCW-1:0]         vcnt_dec;

  logic                   in_fire, out_free, is_read;
  logic [STAT_W-1:0]      dec_status;
  logic signed [IW-1:0]   off_s, g_eff, pend_s, cfg_g, arg_idx, call_nf;
  logic [WORD_W-1:0]      pk, call_word;
  logic signed [IW-1:0]   pk_top, pk_frame;
  logic [OFF_W:0]         vcnt_p1;

  cfsu_cell_ram #(.DEPTH(STACK_DEPTH), .AW(AW)) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .q_r   (mem_q)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign is_read  = (req_r == REQ_LRD) || (req_r == REQ_ARD) || (req_r == REQ_GRD);
  assign off_s    = $signed({{(IW-OFF_W){1'b0}}, off_r});
  assign pend_s   = $signed({{(IW-PEND_W){1'b0}}, pend_r});
  assign g_eff    = ($signed({{(IW-GC_W){1'b0}}, gc_r}) > SDI) ? SDI
                    : $signed({{(IW-GC_W){1'b0}}, gc_r});
  assign cfg_g    = ($signed({{(IW-GC_W){1'b0}}, cfg_wr_data}) > SDI) ? SDI
                    : $signed({{(IW-GC_W){1'b0}}, cfg_wr_data});
  assign arg_idx  = frame_r + ENVI + IW'(1) + off_s;
  assign call_nf  = top_r - ENVI;
  assign vcnt_dec = vcnt_r - VCW'(1);
  assign vcnt_p1  = (OFF_W+1)'(vcnt_r) + (OFF_W+1)'(1);

  // Out-of-range peeks read as zero
  assign pk       = oor_r ? '0 : mem_q[WORD_W-1:0];
  assign pk_top   = (pk > TOPMAX_W) ? TOPMAX : $signed(pk[IW-1:0]);
  assign pk_frame = (pk > SD_W) ? TOPMAX : ($signed(pk[IW-1:0]) - IW'(1));

  always_comb begin
    call_word = '0;
    if (cnt_r == CW'(1)) begin
      call_word = {{(WORD_W-IW){1'b0}}, frame_r + IW'(1)};
    end else if (cnt_r == CW'(2)) begin
      call_word = {{(WORD_W-IW){1'b0}}, top_r + pend_s};
    end else if (cnt_r == CW'(3)) begin
      call_word = {{(WORD_W-PC_W){1'b0}}, pc_r + PC_W'(1)};
    end else if (cnt_r == CW'(4)) begin
      call_word = {{(WORD_W-PEND_W){1'b0}}, pend_r};
    end
  end

  always_comb begin
    dec_status = ST_OK;
    case (req_r)
      REQ_PUSH: begin
        if (vcnt_r != '0) dec_status = ST_FRAME;
        else if (top_r < 0 || pend_r >= PEND_MAX) dec_status = ST_OVF;
      end
      REQ_CALL: begin
        if (vcnt_r != '0) dec_status = ST_FRAME;
        else if (top_r < ENVI - IW'(1) || depth_r >= DEPTH_MAX) dec_status = ST_OVF;
      end
      REQ_RET: begin
        if (vcnt_r != '0 || depth_r == '0) dec_status = ST_FRAME;
      end
      REQ_LRD, REQ_LWR: begin
        if (depth_r == '0) dec_status = ST_FRAME;
        else if (off_s > frame_r || frame_r - off_s <= top_r) dec_status = ST_RANGE;
      end
      REQ_ARD, REQ_AWR: begin
        if (depth_r == '0) dec_status = ST_FRAME;
      end
      REQ_GRD, REQ_GWR: begin
        if (off_s >= g_eff) dec_status = ST_RANGE;
      end
      REQ_UP: begin
        if (!({1'b0, depth_r} > vcnt_p1 && vcnt_r < VCW'(VIEW_DEPTH)))
          dec_status = ST_FRAME;
      end
      REQ_DOWN: begin
        if (vcnt_r == '0) dec_status = ST_FRAME;
      end
      default: dec_status = ST_FRAME;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: if (ptr_r == TOPMAX) state_nxt = S_IDLE;
      S_IDLE: if (in_fire) state_nxt = S_DEC;
      S_DEC: begin
        if (dec_status != ST_OK) begin
          state_nxt = S_DONE;
        end else begin
          case (req_r)
            REQ_CALL:                           state_nxt = S_CALL;
            REQ_RET, REQ_UP:                    state_nxt = S_RT2;
            REQ_LRD, REQ_LWR, REQ_GRD, REQ_GWR: state_nxt = S_ACC;
            REQ_ARD, REQ_AWR:                   state_nxt = S_ARG;
            default:                            state_nxt = S_DONE;
          endcase
        end
      end
      S_CALL: if (cnt_r == CW'(ENV_CELLS)) state_nxt = S_DONE;
      S_RT2:  state_nxt = S_RT3;
      S_RT3:  state_nxt = (req_r == REQ_UP) ? S_DONE : S_RT4;
      S_RT4:  state_nxt = (tmp_top_r > top_r) ? S_CLR : S_DONE;
      S_CLR:  if (ptr_r == top_r) state_nxt = S_DONE;
      S_ARG: begin
        if ({{(WORD_W-OFF_W){1'b0}}, off_r} >= pk || arg_idx <= top_r || arg_idx > TOPMAX)
          state_nxt = S_DONE;
        else
          state_nxt = S_ACC;
      end
      S_ACC:  state_nxt = is_read ? S_ACCW : S_DONE;
      S_ACCW: state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
    if (cfg_wr_en) state_nxt = S_INIT;
  end

  // Datapath and memory control
  always_comb begin
    gc_nxt        = gc_r;
    top_nxt       = top_r;
    frame_nxt     = frame_r;
    pend_nxt      = pend_r;
    depth_nxt     = depth_r;
    vcnt_nxt      = vcnt_r;
    req_nxt       = req_r;
    off_nxt       = off_r;
    val_nxt       = val_r;
    pc_nxt        = pc_r;
    status_nxt    = status_r;
    rval_nxt      = rval_r;
    rok_nxt       = rok_r;
    rpc_nxt       = rpc_r;
    idx_nxt       = idx_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    tmp_top_nxt   = tmp_top_r;
    tmp_frame_nxt = tmp_frame_r;
    oor_nxt       = oor_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_a         = ptr_r;
    mem_wdata     = '0;
    vs_we         = 1'b0;

    case (state_r)
      S_INIT: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + IW'(1);
      end
      S_IDLE: begin
        if (in_fire) begin
          req_nxt    = in_tdata[3:0];
          off_nxt    = in_tdata[13:4];
          val_nxt    = in_tdata[45:14];
          pc_nxt     = in_tdata[61:46];
          status_nxt = ST_OK;
          rval_nxt   = '0;
          rok_nxt    = 1'b0;
          rpc_nxt    = '0;
        end
      end
      S_DEC: begin
        status_nxt = dec_status;
        if (dec_status == ST_OK) begin
          case (req_r)
            REQ_PUSH: begin
              mem_we    = 1'b1;
              mem_a     = top_r;
              mem_wdata = {1'b1, val_r};
              top_nxt   = top_r - IW'(1);
              pend_nxt  = pend_r + PEND_W'(1);
            end
            REQ_CALL: cnt_nxt = CW'(1);
            REQ_RET, REQ_UP: begin
              mem_a   = frame_r + IW'(2);
              oor_nxt = (frame_r + IW'(2)) > TOPMAX;
              if (req_r == REQ_UP) begin
                vs_we    = 1'b1;
                vcnt_nxt = vcnt_r + VCW'(1);
              end
            end
            REQ_LRD, REQ_LWR: idx_nxt = frame_r - off_s;
            REQ_GRD, REQ_GWR: idx_nxt = TOPMAX - off_s;
            REQ_ARD, REQ_AWR: begin
              mem_a   = frame_r + IW'(4);
              oor_nxt = (frame_r + IW'(4)) > TOPMAX;
            end
            REQ_DOWN: begin
              vcnt_nxt  = vcnt_dec;
              top_nxt   = $signed(vs_q_r[2*IW-1:IW]);
              frame_nxt = $signed(vs_q_r[IW-1:0]);
            end
            default: ;
          endcase
        end
      end
      S_CALL: begin
        mem_we    = 1'b1;
        mem_a     = call_nf + $signed({{(IW-CW){1'b0}}, cnt_r});
        mem_wdata = {1'b1, call_word};
        cnt_nxt   = cnt_r + CW'(1);
        if (cnt_r == CW'(ENV_CELLS)) begin
          top_nxt   = call_nf;
          frame_nxt = call_nf;
          pend_nxt  = '0;
          depth_nxt = depth_r + DEPTH_W'(1);
        end
      end
      S_RT2: begin
        tmp_top_nxt = pk_top;
        mem_a       = frame_r + IW'(1);
        oor_nxt     = (frame_r + IW'(1)) > TOPMAX;
      end
      S_RT3: begin
        tmp_frame_nxt = pk_frame;
        if (req_r == REQ_UP) begin
          top_nxt   = tmp_top_r;
          frame_nxt = pk_frame;
        end else begin
          mem_a   = frame_r + IW'(3);
          oor_nxt = (frame_r + IW'(3)) > TOPMAX;
        end
      end
      S_RT4: begin
        rpc_nxt   = pk[PC_W-1:0];
        frame_nxt = tmp_frame_r;
        top_nxt   = tmp_top_r;
        depth_nxt = depth_r - DEPTH_W'(1);
        ptr_nxt   = top_r + IW'(1);
      end
      S_CLR: begin
        // wipe the freed run up to the restored top
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + IW'(1);
      end
      S_ARG: begin
        if ({{(WORD_W-OFF_W){1'b0}}, off_r} >= pk || arg_idx <= top_r || arg_idx > TOPMAX)
          status_nxt = ST_RANGE;
        else
          idx_nxt = arg_idx;
      end
      S_ACC: begin
        mem_a     = idx_r;
        mem_we    = !is_read;
        mem_wdata = {1'b1, val_r};
      end
      S_ACCW: begin
        rval_nxt = mem_q[WORD_W-1:0];
        rok_nxt  = mem_q[WORD_W];
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'd0, depth_r, rpc_r, rok_r, rval_r, status_r};
        end
      end
      default: ;
    endcase

    // a global_count write restarts the whole stack
    if (cfg_wr_en) begin
      gc_nxt    = cfg_wr_data;
      top_nxt   = TOPMAX - cfg_g;
      frame_nxt = TOPMAX - cfg_g;
      pend_nxt  = '0;
      depth_nxt = '0;
      vcnt_nxt  = '0;
      ptr_nxt   = '0;
    end
  end

  assign mem_addr = mem_a[AW-1:0];

  always_ff @(posedge clk) begin
    if (vs_we) begin
      vs_mem[vcnt_r[VAW-1:0]] <= {top_r, frame_r};
    end
    vs_q_r <= vs_mem[vcnt_dec[VAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      gc_r        <= '0;
      top_r       <= TOPMAX;
      frame_r     <= TOPMAX;
      pend_r      <= '0;
      depth_r     <= '0;
      vcnt_r      <= '0;
      ptr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gc_r        <= gc_nxt;
      top_r       <= top_nxt;
      frame_r     <= frame_nxt;
      pend_r      <= pend_nxt;
      depth_r     <= depth_nxt;
      vcnt_r      <= vcnt_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    off_r       <= off_nxt;
    val_r       <= val_nxt;
    pc_r        <= pc_nxt;
    status_r    <= status_nxt;
    rval_r      <= rval_nxt;
    rok_r       <= rok_nxt;
    rpc_r       <= rpc_nxt;
    idx_r       <= idx_nxt;
    tmp_top_r   <= tmp_top_nxt;
    tmp_frame_r <= tmp_frame_nxt;
    oor_r       <= oor_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

// ----- dv/tb_call_frame_stack_unit.sv -----
// Self-checking testbench for the call frame stack unit with its own software stack model.
module tb_call_frame_stack_unit;
  import cfsu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCELL = CFSU_STACK_DEPTH;
  localparam int NENV  = CFSU_ENV_CELLS;
  localparam int NVIEW = CFSU_VIEW_DEPTH;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [WORD_W-1:0]  rd_word;
    logic               rd_mark;
    logic [PC_W-1:0]    ret_pc;
    logic [DEPTH_W-1:0] depth;
  } frame_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [63:0]      in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [63:0]      out_tdata;
  logic             cfg_wr_en = 1'b0;
  logic [GC_W-1:0]  cfg_wr_data = '0;

  call_frame_stack_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #4 clk = ~clk;

  // Software copy of the stack
  logic [31:0] sw_word [NCELL];
  bit          sw_mark [NCELL];
  int          sw_globals, sw_top, sw_frame, sw_depth, sw_views;
  int unsigned sw_pending;
  int          sw_view_top [NVIEW];
  int          sw_view_frame [NVIEW];

  frame_result_t results_due [$];
  int errors = 0;
  int cycles = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold = 0;

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic void stack_clear(int globals);
    for (int i = 0; i < NCELL; i++) begin
      sw_word[i] = '0;
      sw_mark[i] = 1'b0;
    end
    sw_globals = globals;
    sw_top = NCELL - 1 - globals;
    sw_frame = sw_top;
    sw_pending = 0;
    sw_depth = 0;
    sw_views = 0;
  endfunction

  function automatic logic [31:0] cell_at(int i);
    return (i < 0 || i >= NCELL) ? 32'd0 : sw_word[i];
  endfunction

  function automatic void cell_put(int i, logic [31:0] v);
    if (i >= 0 && i < NCELL) begin
      sw_word[i] = v;
      sw_mark[i] = 1'b1;
    end
  endfunction

  function automatic int ptr_of(logic [31:0] u, int bias);
    return ((u > NCELL) ? NCELL : int'(u)) - bias;
  endfunction

  // Apply one request to the software stack and return the result it yields
  function automatic frame_result_t stack_step(logic [3:0] req, logic [9:0] off,
                                               logic [31:0] val, logic [15:0] pc);
    frame_result_t r;
    int idx, nf, old, nt, o;
    r = '0;
    idx = -1;
    o = int'(off);
    case (req)
      REQ_PUSH: begin
        if (sw_views != 0) r.status = ST_FRAME;
        else if (sw_top < 0 || sw_pending >= PEND_MAX) r.status = ST_OVF;
        else begin
          cell_put(sw_top, val);
          sw_top--;
          sw_pending++;
        end
      end
      REQ_CALL: begin
        if (sw_views != 0) r.status = ST_FRAME;
        else if (sw_top < NENV - 1 || sw_depth >= DEPTH_MAX) r.status = ST_OVF;
        else begin
          nf = sw_top - NENV;
          for (int i = 1; i <= NENV; i++) cell_put(nf + i, '0);
          cell_put(nf + 1, sw_frame + 1);
          cell_put(nf + 2, nf + NENV + int'(sw_pending));
          cell_put(nf + 3, {16'd0, pc + 16'd1});
          cell_put(nf + 4, sw_pending);
          sw_top = nf;
          sw_frame = nf;
          sw_pending = 0;
          sw_depth++;
        end
      end
      REQ_RET: begin
        if (sw_views != 0 || sw_depth == 0) r.status = ST_FRAME;
        else begin
          old = sw_top;
          nt = ptr_of(cell_at(sw_frame + 2), 0);
          r.ret_pc = PC_W'(cell_at(sw_frame + 3));
          sw_frame = ptr_of(cell_at(sw_frame + 1), 1);
          if (nt > NCELL - 1) nt = NCELL - 1;
          sw_top = nt;
          for (int i = old + 1; i <= nt; i++) begin
            if (i >= 0) begin
              sw_word[i] = '0;
              sw_mark[i] = 1'b0;
            end
          end
          sw_depth--;
        end
      end
      REQ_LRD, REQ_LWR: begin
        if (sw_depth == 0) r.status = ST_FRAME;
        else if (o > sw_frame || sw_frame - o <= sw_top) r.status = ST_RANGE;
        else idx = sw_frame - o;
      end
      REQ_ARD, REQ_AWR: begin
        if (sw_depth == 0) r.status = ST_FRAME;
        else if (o >= cell_at(sw_frame + 4)) r.status = ST_RANGE;
        else begin
          idx = sw_frame + NENV + 1 + o;
          if (idx <= sw_top || idx >= NCELL) begin
            idx = -1;
            r.status = ST_RANGE;
          end
        end
      end
      REQ_GRD, REQ_GWR: begin
        if (o >= sw_globals) r.status = ST_RANGE;
        else idx = NCELL - 1 - o;
      end
      REQ_UP: begin
        if (sw_depth <= sw_views + 1 || sw_views >= NVIEW) r.status = ST_FRAME;
        else begin
          sw_view_top[sw_views] = sw_top;
          sw_view_frame[sw_views] = sw_frame;
          sw_views++;
          sw_top = ptr_of(cell_at(sw_frame + 2), 0);
          if (sw_top > NCELL - 1) sw_top = NCELL - 1;
          sw_frame = ptr_of(cell_at(sw_frame + 1), 1);
        end
      end
      REQ_DOWN: begin
        if (sw_views == 0) r.status = ST_FRAME;
        else begin
          sw_views--;
          sw_top = sw_view_top[sw_views];
          sw_frame = sw_view_frame[sw_views];
        end
      end
      default: r.status = ST_FRAME;
    endcase
    if (r.status == ST_OK && idx >= 0 && idx < NCELL) begin
      if (req == REQ_LRD || req == REQ_ARD || req == REQ_GRD) begin
        r.rd_word = sw_word[idx];
        r.rd_mark = sw_mark[idx];
      end else begin
        sw_word[idx] = val;
        sw_mark[idx] = 1'b1;
      end
    end
    r.depth = sw_depth[DEPTH_W-1:0];
    return r;
  endfunction

  // Offer one request, hold it until taken, then predict its result
  task automatic send_req(logic [3:0] req, logic [9:0] off = '0,
                          logic [31:0] val = '0, logic [15:0] pc = '0);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, pc, val, off, req};
    do @(posedge clk); while (!in_tready);
    results_due.push_back(stack_step(req, off, val, pc));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    wait (results_due.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_globals(int globals);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= globals[GC_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    stack_clear(globals);
  endtask

  // Result checker
  always @(posedge clk) begin
    frame_result_t got, want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL call_frame_stack_unit");
      $finish;
    end
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tdata[1:0];
      got.rd_word = out_tdata[33:2];
      got.rd_mark = out_tdata[34];
      got.ret_pc = out_tdata[50:35];
      got.depth = out_tdata[59:51];
      if (results_due.size() == 0) begin
        report("unexpected beat", out_tdata, 0);
      end else begin
        want = results_due.pop_front();
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.rd_word !== want.rd_word) report("read_value", got.rd_word, want.rd_word);
        if (got.rd_mark !== want.rd_mark) report("read_valid", got.rd_mark, want.rd_mark);
        if (got.ret_pc !== want.ret_pc) report("return_pc", got.ret_pc, want.ret_pc);
        if (got.depth !== want.depth) report("call_depth", got.depth, want.depth);
      end
    end
  end

  task automatic test_frames();
    set_globals(8);
    send_req(REQ_PUSH, 0, 32'hFFFF_FFFF);
    send_req(REQ_PUSH, 0, 32'h0);
    send_req(REQ_CALL, 0, 0, 16'hFFFF);     // saved pc wraps to zero
    send_req(REQ_PUSH, 0, 32'hA5A5_5A5A);
    send_req(REQ_LWR, 0, 32'h1234_5678);
    send_req(REQ_LRD, 0);
    send_req(REQ_LRD, 1);
    send_req(REQ_ARD, 0);
    send_req(REQ_AWR, 1, 32'hDEAD_BEEF);
    send_req(REQ_ARD, 1);
    send_req(REQ_ARD, 2);
    send_req(REQ_GWR, 7, 32'h8000_0001);
    send_req(REQ_GRD, 7);
    send_req(REQ_GRD, 3);                   // never written: mark stays low
    send_req(REQ_GRD, 10'h3FF);
    send_req(REQ_CALL, 0, 0, 16'h0);
    send_req(REQ_UP);
    send_req(REQ_UP);                       // no grandparent frame to view
    send_req(REQ_LRD, 0);
    send_req(REQ_PUSH, 0, 32'h1);           // blocked while viewing
    send_req(REQ_DOWN);
    send_req(REQ_DOWN);
    send_req(REQ_RET);
    send_req(REQ_RET);
    send_req(REQ_RET);
    send_req(REQ_LRD, 0);
    send_req(REQ_DOWN + 4'd1);
    send_req(4'hF);
  endtask

  task automatic test_overflow();
    set_globals(1019);
    send_req(REQ_CALL, 0, 0, 16'h0042);
    send_req(REQ_PUSH, 0, 32'h5555_AAAA);
    send_req(REQ_PUSH, 0, 32'h2);
    send_req(REQ_CALL, 0, 0, 16'h0043);
    send_req(REQ_GRD, 1018);
    send_req(REQ_RET);
    send_req(REQ_LRD, 0);
  endtask

  // Fill the pending argument count to its limit with no globals
  task automatic test_pending_limit();
    set_globals(0);
    for (int i = 0; i < 1025; i++) send_req(REQ_PUSH, 0, $urandom());
    send_req(REQ_GRD, 0);
    send_req(REQ_GWR, 0, 32'h7);
  endtask

  task automatic random_mix(int n);
    logic [3:0] req;
    logic [9:0] off;
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (sw_views != 0 && roll < 40) req = REQ_DOWN;
      else if (roll < 18) req = REQ_PUSH;
      else if (roll < 30) req = (sw_depth < 6) ? REQ_CALL : REQ_RET;
      else if (roll < 38) req = REQ_RET;
      else if (roll < 50) req = ($urandom_range(0, 1) != 0) ? REQ_LRD : REQ_LWR;
      else if (roll < 62) req = ($urandom_range(0, 1) != 0) ? REQ_ARD : REQ_AWR;
      else if (roll < 76) req = ($urandom_range(0, 1) != 0) ? REQ_GRD : REQ_GWR;
      else if (roll < 86) req = REQ_UP;
      else if (roll < 94) req = REQ_DOWN;
      else if (roll < 97) req = 4'($urandom_range(0, 15));
      else req = REQ_CALL;
      off = ($urandom_range(0, 99) < 85) ? 10'($urandom_range(0, 7))
                                         : 10'($urandom_range(0, 1023));
      send_req(req, off, $urandom(), 16'($urandom()));
    end
  endtask

  // Block the result side while requests keep coming, then let it all drain
  task automatic test_backpressure();
    set_globals(32);
    rx_hold = 400;
    random_mix(60);
    drain();
  endtask

  task automatic test_random();
    tx_idle_pct = 23;
    rx_idle_pct = 67;
    set_globals(16);
    random_mix(300);
    tx_idle_pct = 67;
    rx_idle_pct = 23;
    set_globals($urandom_range(1, 1019));
    random_mix(300);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_globals(500);
    random_mix(250);
  endtask

  initial begin
    stack_clear(0);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_frames();
    test_overflow();
    test_pending_limit();
    test_backpressure();
    test_random();
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("PASS call_frame_stack_unit");
    end else begin
      $display("FAIL call_frame_stack_unit");
    end
    $finish;
  end

endmodule
